// ----- rtl/ucrf_pkg.sv -----
// ----------------------------------------------------------------------------
// ucrf_pkg
// shared types, constants and decode functions of the utf-8 range filter
// ----------------------------------------------------------------------------
package ucrf_pkg;

  // default depth of the run queue between decoder and serializer
  localparam int FifoDepth = 4;

  localparam int RunBytes = 4;

  // lengths of a sequence as given by its lead byte
  localparam logic [2:0] LenInvalid = 3'd0;
  localparam logic [2:0] LenOne     = 3'd1;
  localparam logic [2:0] LenTwo     = 3'd2;
  localparam logic [2:0] LenThree   = 3'd3;
  localparam logic [2:0] LenFour    = 3'd4;

  // dropped code point ranges
  localparam logic [20:0] CpSpace     = 21'h00020;
  localparam logic [20:0] CpDel       = 21'h0007F;
  localparam logic [20:0] CpSymLo     = 21'h02600;
  localparam logic [20:0] CpSymHi     = 21'h027BF;
  localparam logic [20:0] CpPicLo     = 21'h1F000;
  localparam logic [20:0] CpPicHi     = 21'h1FFFF;
  localparam logic [20:0] CpVsLo      = 21'h0FE00;
  localparam logic [20:0] CpVsHi      = 21'h0FE0F;
  localparam logic [20:0] CpPuaLo     = 21'h0E000;
  localparam logic [20:0] CpPuaHi     = 21'h0F8FF;

  // one run of bytes to emit: last_idx is the index of the final byte
  typedef struct packed {
    logic [RunBytes-1:0][7:0] bytes;
    logic [1:0]               last_idx;
  } run_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LenInvalid;
    priority if (b[7] == 1'b0)        len = LenOne;
    else if (b[7:5] == 3'b110)        len = LenTwo;
    else if (b[7:4] == 4'b1110)       len = LenThree;
    else if (b[7:3] == 5'b11110)      len = LenFour;
    else                              len = LenInvalid;
    return len;
  endfunction

  // lead payload bits moved to their place in the code point
  function automatic logic [20:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
    logic [20:0] cp;
    unique case (len)
      LenOne:   cp = {13'd0, b};
      LenTwo:   cp = {10'd0, b[4:0], 6'd0};
      LenThree: cp = {5'd0, b[3:0], 12'd0};
      LenFour:  cp = {b[2:0], 18'd0};
      default:  cp = 21'd0;
    endcase
    return cp;
  endfunction

  function automatic logic cp_kept(input logic [20:0] cp);
    logic keep;
    keep = 1'b1;
    if (cp < CpSpace || cp == CpDel)            keep = 1'b0;
    if (cp >= CpSymLo && cp <= CpSymHi)         keep = 1'b0;
    if (cp >= CpPicLo && cp <= CpPicHi)         keep = 1'b0;
    if (cp >= CpVsLo && cp <= CpVsHi)           keep = 1'b0;
    if (cp >= CpPuaLo && cp <= CpPuaHi)         keep = 1'b0;
    return keep;
  endfunction

endpackage

// ----- rtl/ucrf_in_if.sv -----
// ----------------------------------------------------------------------------
// ucrf_in_if
// input byte channel: valid/ready with one text byte and end flag per beat
// ----------------------------------------------------------------------------
interface ucrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source(output valid, output byte_in, output end_of_text, input ready);
  modport sink(input valid, input byte_in, input end_of_text, output ready);
endinterface

// ----- rtl/ucrf_out_if.sv -----
// ----------------------------------------------------------------------------
// ucrf_out_if
// result byte channel: valid/ready with one kept byte and run end flag per beat
// ----------------------------------------------------------------------------
interface ucrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       run_end;

  modport source(output valid, output byte_out, output run_end, input ready);
  modport sink(input valid, input byte_out, input run_end, output ready);
endinterface

// ----- rtl/ucrf_front.sv -----
// ----------------------------------------------------------------------------
// ucrf_front
// sequence decoder: tracks the open sequence and pushes kept runs
// ----------------------------------------------------------------------------
module ucrf_front (
  input  logic             clk,
  input  logic             rst_n,
  ucrf_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output ucrf_pkg::run_t   run
);

  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [7:0]  held_r [3];

  logic        accept;
  logic [2:0]  len;
  logic [2:0]  pos_p1;
  logic [2:0]  sel;
  logic [20:0] cont_bits;
  logic [20:0] cp_merged;
  logic        complete;
  logic        emit;
  logic        hold_wr;
  logic [7:0]  b;

  assign b           = in_ch.byte_in;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign pos_p1      = {1'b0, held_cnt_r} + 3'd1;
  assign complete    = pos_p1 >= seq_len_r;
  // remaining continuation slots below this byte
  assign sel         = complete ? 3'd0 : seq_len_r - pos_p1;

  always_comb begin
    unique case (sel)
      3'd1:    cont_bits = {9'd0, b[5:0], 6'd0};
      3'd2:    cont_bits = {3'd0, b[5:0], 12'd0};
      default: cont_bits = {15'd0, b[5:0]};
    endcase
  end

  assign cp_merged = cp_r | cont_bits;

  always_comb begin
    len          = ucrf_pkg::lead_len(b);
    emit         = 1'b0;
    hold_wr      = 1'b0;
    seq_len_nxt  = seq_len_r;
    held_cnt_nxt = held_cnt_r;
    cp_nxt       = cp_r;
    if (seq_len_r == ucrf_pkg::LenInvalid) begin
      if (len == ucrf_pkg::LenOne) begin
        emit = ucrf_pkg::cp_kept({13'd0, b});
      end else if (len == ucrf_pkg::LenInvalid) begin
        emit = 1'b0;
      end else if (in_ch.end_of_text) begin
        emit = ucrf_pkg::cp_kept(ucrf_pkg::lead_bits(b, len));
      end else begin
        hold_wr      = 1'b1;
        seq_len_nxt  = len;
        held_cnt_nxt = 2'd1;
        cp_nxt       = ucrf_pkg::lead_bits(b, len);
      end
    end else begin
      if (complete) begin
        emit         = ucrf_pkg::cp_kept(cp_merged);
        seq_len_nxt  = 3'd0;
        held_cnt_nxt = 2'd0;
        cp_nxt       = 21'd0;
      end else if (in_ch.end_of_text) begin
        emit         = ucrf_pkg::cp_kept(ucrf_pkg::lead_bits(held_r[0], seq_len_r));
        seq_len_nxt  = 3'd0;
        held_cnt_nxt = 2'd0;
        cp_nxt       = 21'd0;
      end else begin
        hold_wr      = 1'b1;
        held_cnt_nxt = pos_p1[1:0];
        cp_nxt       = cp_merged;
      end
    end
  end

  // run is the held bytes followed by this byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < held_cnt_r) run.bytes[k] = held_r[k];
      else                    run.bytes[k] = b;
    end
    run.bytes[ucrf_pkg::RunBytes-1] = b;
    run.last_idx = held_cnt_r;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r  <= 3'd0;
      held_cnt_r <= 2'd0;
      cp_r       <= 21'd0;
    end else if (accept) begin
      seq_len_r  <= seq_len_nxt;
      held_cnt_r <= held_cnt_nxt;
      cp_r       <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held_r[held_cnt_r] <= b;
    end
  end

endmodule

// ----- rtl/ucrf_queue.sv -----
// ----------------------------------------------------------------------------
// ucrf_queue
// small run queue between decoder and serializer
// ----------------------------------------------------------------------------
module ucrf_queue #(
  parameter int FIFO_DEPTH = ucrf_pkg::FifoDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ucrf_pkg::run_t push_run,
  input  logic           pop,
  output ucrf_pkg::run_t head,
  output logic           empty,
  output logic           full
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  ucrf_pkg::run_t mem_r [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign empty   = cnt_r == CntW'(0);
  assign full    = cnt_r == CntW'(FIFO_DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(FIFO_DEPTH - 1)) ? PtrW'(0) : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CntW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_run;
  end

endmodule

// ----- rtl/ucrf_back.sv -----
// ----------------------------------------------------------------------------
// ucrf_back
// run serializer: sends the bytes of the head run one beat at a time
// ----------------------------------------------------------------------------
module ucrf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ucrf_pkg::run_t head,
  input  logic           empty,
  output logic           pop,
  ucrf_out_if.source     out_ch
);

  logic [1:0] idx_r;
  logic       fire;
  logic       last_beat;

  assign last_beat       = idx_r == head.last_idx;
  assign out_ch.valid    = !empty;
  assign out_ch.byte_out = head.bytes[idx_r];
  assign out_ch.run_end  = last_beat;
  assign fire            = out_ch.valid && out_ch.ready;
  assign pop             = fire && last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (fire) begin
      idx_r <= last_beat ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ----- rtl/utf8_codepoint_range_filter.sv -----
// ----------------------------------------------------------------------------
// utf8_codepoint_range_filter
// streaming utf-8 filter that forwards only the bytes of kept characters
// ----------------------------------------------------------------------------
// in_ch takes one text byte per beat plus an end_of_text flag; out_ch gives
// the bytes of each kept character in original order, run_end set on the
// last byte that a given input byte releases (a character ends a run)
// a character is dropped when its code point is a control code, DEL,
// 0x2600-0x27BF, 0x1F000-0x1FFFF, a variation selector or private use
// throughput: one input byte per cycle while the run queue has room; each
// input byte releases 0 to 4 output beats, one per cycle while out_ch is ready
// latency: with the run queue empty, the first beat of a run is valid the
// cycle after the byte that completes the character is taken
// the decoder state sits in the front, the byte serializer in the back, with
// a queue of FIFO_DEPTH runs between them; in_ch.ready drops only when
// that queue is full
// reset (rst_n low at a clock edge) closes any open sequence and empties
// the queue; a stalled out_ch holds its byte and fills the queue, then
// backpressures in_ch
// ----------------------------------------------------------------------------
module utf8_codepoint_range_filter #(
  parameter int FIFO_DEPTH = ucrf_pkg::FifoDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  ucrf_in_if.sink     in_ch,
  ucrf_out_if.source  out_ch
);

  // decoder to queue
  logic           push;
  ucrf_pkg::run_t push_run;

  // queue to serializer
  ucrf_pkg::run_t head;
  logic           q_empty;
  logic           q_full;
  logic           pop;

  // front: decode lead and continuation bytes, judge each finished character
  ucrf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .run    (push_run)
  );

  // runs waiting for the serializer
  ucrf_queue #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: one beat per byte of the head run
  ucrf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue never reports empty and full together
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_empty && q_full))
    else $error("run queue empty and full at once");

  // a run pushed into an empty queue is visible next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_empty) |=> out_ch.valid)
    else $error("pushed run not presented");

  // the run_end beat retires exactly one queue entry
  a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.run_end) |-> pop)
    else $error("run end without pop");

  // input is refused only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_full)
    else $error("input stalled with room in queue");

endmodule
